// ----- hw/rtl/hsp_pkg.sv -----
// hsp_pkg: shared types, symbol codes, boundary-rule tables and the per-syllable
// symbol function of the hangul syllable to phoneme block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsp_pkg;

  // precomposed syllable range
  localparam logic [20:0] SYL_BASE = 21'h00AC00;
  localparam logic [20:0] SYL_LAST = 21'h00D7A3;

  // reciprocals for division by 588 (21 * 28) and by 28
  localparam logic [14:0] INI_RECIP = 15'd28533;  // ceil(2^24 / 588)
  localparam int          INI_SHIFT = 24;
  localparam logic [13:0] Q28_RECIP = 14'd9363;   // ceil(2^18 / 28)
  localparam int          Q28_SHIFT = 18;

  // jamo indexes
  localparam logic [4:0] FINAL_NONE = 5'd0;
  localparam logic [4:0] FINAL_N    = 5'd4;
  localparam logic [4:0] FINAL_L    = 5'd8;
  localparam logic [4:0] FINAL_NG   = 5'd21;
  localparam logic [4:0] FINAL_H    = 5'd27;
  localparam logic [4:0] INIT_K     = 5'd0;
  localparam logic [4:0] INIT_N     = 5'd2;
  localparam logic [4:0] INIT_T     = 5'd3;
  localparam logic [4:0] INIT_R     = 5'd5;
  localparam logic [4:0] INIT_M     = 5'd6;
  localparam logic [4:0] INIT_P     = 5'd7;
  localparam logic [4:0] INIT_S     = 5'd9;
  localparam logic [4:0] INIT_SS    = 5'd10;
  localparam logic [4:0] INIT_NULL  = 5'd11;
  localparam logic [4:0] INIT_C     = 5'd12;
  localparam logic [4:0] INIT_COUNT = 5'd19;
  localparam logic [4:0] VOWEL_I    = 5'd20;

  // onset symbol codes
  localparam logic [4:0] ON_NONE = 5'd0;
  localparam logic [4:0] ON_KK   = 5'd2;
  localparam logic [4:0] ON_KH   = 5'd3;
  localparam logic [4:0] ON_TT   = 5'd6;
  localparam logic [4:0] ON_TH   = 5'd7;
  localparam logic [4:0] ON_PP   = 5'd11;
  localparam logic [4:0] ON_PH   = 5'd12;
  localparam logic [4:0] ON_SS   = 5'd14;
  localparam logic [4:0] ON_TC   = 5'd15;
  localparam logic [4:0] ON_TTC  = 5'd16;
  localparam logic [4:0] ON_SH   = 5'd18;
  localparam logic [4:0] ON_SSH  = 5'd19;

  // coda symbol codes
  localparam logic [2:0] CODA_NONE = 3'd0;

  // result queue depth default
  localparam int RESULT_DEPTH_DEF = 4;

  typedef struct packed {
    logic [4:0] onset;
    logic [4:0] vowel;
    logic [2:0] coda;
    logic       first;
    logic       last;
  } syl_out_t;

  // final left behind when the final links into a null onset
  localparam logic [4:0] LINK_KEEP [28] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 5'd4, 5'd0, 5'd0, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8,
    5'd8, 5'd8, 5'd0, 5'd0, 5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
  // initial that the linked consonant becomes
  localparam logic [4:0] LINK_MOVE [28] = '{
    5'd0, 5'd0, 5'd1, 5'd9, 5'd2, 5'd12, 5'd18, 5'd3, 5'd5, 5'd0, 5'd6, 5'd7, 5'd9, 5'd16,
    5'd17, 5'd18, 5'd6, 5'd7, 5'd9, 5'd9, 5'd10, 5'd0, 5'd12, 5'd14, 5'd15, 5'd16, 5'd17,
    5'd18};
  // obstruent finals that tense the next onset
  localparam logic TENSE_TRIG [28] = '{
    1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam logic [4:0] ONSET_PLAIN [19] = '{
    5'd1, 5'd2, 5'd4, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10, 5'd11, 5'd13, 5'd14, 5'd0, 5'd15,
    5'd16, 5'd15, 5'd3, 5'd7, 5'd12, 5'd17};
  localparam logic [2:0] CODA_PLAIN [28] = '{
    3'd0, 3'd1, 3'd1, 3'd1, 3'd4, 3'd4, 3'd4, 3'd2, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd3, 3'd3, 3'd2, 3'd2, 3'd7, 3'd2, 3'd2, 3'd1, 3'd2, 3'd3, 3'd2};
  // zero: no nasal form, use the plain coda
  localparam logic [2:0] CODA_NASAL [28] = '{
    3'd0, 3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd7, 3'd0, 3'd6, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd0, 3'd6, 3'd6, 3'd4, 3'd4, 3'd0, 3'd4, 3'd4, 3'd7, 3'd4, 3'd6, 3'd4};

  function automatic logic is_kptc(input logic [4:0] c);
    return (c == INIT_K) || (c == INIT_T) || (c == INIT_P) || (c == INIT_C);
  endfunction

  // symbols of one syllable given its neighbours
  function automatic syl_out_t hsp_emit(input logic [4:0] prev_fin, input logic [4:0] ini,
                                        input logic [4:0] vow, input logic [4:0] fin,
                                        input logic has_next, input logic [4:0] next_ini,
                                        input logic first, input logic last);
    syl_out_t   r;
    logic [4:0] pf;
    logic [4:0] fn;
    logic       asp;
    logic       tns;
    logic [4:0] onset;
    logic [2:0] coda;
    pf    = (prev_fin < 5'd28) ? prev_fin : FINAL_NONE;
    fn    = (fin < 5'd28) ? fin : FINAL_NONE;
    onset = ON_NONE;
    coda  = CODA_NONE;
    asp   = (pf == FINAL_H) && is_kptc(ini);
    tns   = TENSE_TRIG[pf] && (is_kptc(ini) || (ini == INIT_S));
    if ((ini < INIT_COUNT) && (ini != INIT_NULL)) begin
      if (asp) begin
        case (ini)
          INIT_K:  onset = ON_KH;
          INIT_T:  onset = ON_TH;
          INIT_P:  onset = ON_PH;
          default: onset = ON_TC;
        endcase
      end else if (tns) begin
        case (ini)
          INIT_K:  onset = ON_KK;
          INIT_T:  onset = ON_TT;
          INIT_P:  onset = ON_PP;
          INIT_S:  onset = ON_SS;
          default: onset = ON_TTC;
        endcase
      end else begin
        onset = ONSET_PLAIN[ini];
      end
    end
    if ((vow == VOWEL_I) && ((ini == INIT_S) || (ini == INIT_SS)))
      onset = ((onset == ON_SS) || (ini == INIT_SS)) ? ON_SSH : ON_SH;
    if (fn != FINAL_NONE) begin
      if (has_next && (fn == FINAL_H) && is_kptc(next_ini))
        coda = CODA_NONE;
      else if (has_next && ((next_ini == INIT_N) || (next_ini == INIT_M)) &&
               (CODA_NASAL[fn] != CODA_NONE))
        coda = CODA_NASAL[fn];
      else
        coda = CODA_PLAIN[fn];
    end
    r.onset = onset;
    r.vowel = vow;
    r.coda  = coda;
    r.first = first;
    r.last  = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hsp_decompose.sv -----
// hsp_decompose: splits a code point into syllable initial, vowel and final
// indexes by reciprocal multiplication; uses hsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsp_decompose (
  input  wire logic [20:0] code_point,
  output logic             is_syllable,
  output logic [4:0]       ini,
  output logic [4:0]       vow,
  output logic [4:0]       fin
);
  import hsp_pkg::*;

  logic [20:0] code_wide;
  logic [13:0] code;
  logic [28:0] prod_ini;
  logic [27:0] prod_q;
  logic [8:0]  q;
  logic [13:0] q28;
  logic [8:0]  ini21;

  assign is_syllable = (code_point >= SYL_BASE) && (code_point <= SYL_LAST);
  assign code_wide   = code_point - SYL_BASE;
  assign code        = code_wide[13:0];

  // code / 588 and code / 28, exact over the syllable range
  assign prod_ini = 29'(code) * 29'(INI_RECIP);
  assign prod_q   = 28'(code) * 28'(Q28_RECIP);
  assign ini      = prod_ini[INI_SHIFT +: 5];
  assign q        = prod_q[Q28_SHIFT +: 9];

  // remainders by shift and add
  assign q28   = 14'({q, 5'b0}) - 14'({q, 2'b0});
  assign ini21 = 9'({ini, 4'b0}) + 9'({ini, 2'b0}) + 9'(ini);
  assign fin   = 5'(code - q28);
  assign vow   = 5'(q - ini21);

endmodule

`default_nettype wire

// ----- hw/rtl/hsp_result_fifo.sv -----
// hsp_result_fifo: small result queue taking up to two beats a cycle and giving at most one
// uses hsp_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module hsp_result_fifo #(
  parameter int DEPTH = hsp_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  wire hsp_pkg::syl_out_t push_data0,
  input  wire hsp_pkg::syl_out_t push_data1,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output hsp_pkg::syl_out_t     out_data
);
  import hsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  syl_out_t           mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   rd_ptr_inc;
  logic [PTR_W-1:0]   wr_ptr_inc;
  logic [PTR_W-1:0]   wr_ptr_inc2;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic [CNT_W-1:0]   count_next;
  logic               pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  assign out_data   = mem[rd_ptr];
  // room for two beats, so a stage producing two results never overflows
  assign room       = (count <= CNT_W'(DEPTH - 2));

  assign rd_ptr_inc  = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc  = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign wr_ptr_inc2 = (wr_ptr_inc == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_inc + 1'b1;

  always_comb begin
    case (push_n)
      2'd1:    wr_ptr_next = wr_ptr_inc;
      2'd2:    wr_ptr_next = wr_ptr_inc2;
      default: wr_ptr_next = wr_ptr;
    endcase
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) rd_ptr <= rd_ptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_ptr] <= push_data0;
    if (push_n == 2'd2) mem[wr_ptr_inc] <= push_data1;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hangul_syllable_to_phoneme.sv -----
// hangul_syllable_to_phoneme: top level of the syllable to phoneme symbol block
// depends on hsp_pkg, hsp_decompose and hsp_result_fifo
`timescale 1ns / 1ps
`default_nettype none

// Takes one code point per beat, with word_end marking the last beat of a word,
// and gives one beat of onset, vowel and coda symbols per precomposed syllable.
// Code points outside the syllable range give nothing, though their word_end still
// closes the word. One syllable is held back so that the rules across the boundary
// (linking, lateralization, aspiration, tensing, nasal assimilation) can see the
// next initial; a syllable is therefore emitted when the next syllable or the word
// end arrives, and a syllable beat with word_end gives two results if one was held.
// The input takes one beat per cycle, sustained, as long as results are taken as fast
// as they are produced: the path is an input register, a decompose stage register and
// the rule stage that writes a result queue (default depth four). The output side
// gives at most one result per cycle, so a burst of two-result beats slows the input
// to the output rate. The rule stage writes a result to the queue, behind both stage
// registers and only when there is room, and it can be read from the cycle after.

module hangul_syllable_to_phoneme #(
  parameter int RESULT_DEPTH = hsp_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] code_point,
  input  wire logic        word_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       onset_symbol,
  output logic [4:0]       vowel_symbol,
  output logic [2:0]       coda_symbol,
  output logic             word_first,
  output logic             word_last
);
  import hsp_pkg::*;

  // input register
  logic        s1_valid;
  logic [20:0] s1_code_point;
  logic        s1_word_end;

  // decompose stage register
  logic        s2_valid;
  logic        s2_syl;
  logic        s2_wend;
  logic [4:0]  s2_ini;
  logic [4:0]  s2_vow;
  logic [4:0]  s2_fin;

  logic        dec_syl;
  logic [4:0]  dec_ini;
  logic [4:0]  dec_vow;
  logic [4:0]  dec_fin;

  // word state
  logic        held_valid;
  logic [4:0]  held_initial;
  logic [4:0]  held_vowel;
  logic [4:0]  held_final;
  logic [4:0]  previous_final;
  logic        emitted_in_word;

  logic        held_valid_next;
  logic [4:0]  held_initial_next;
  logic [4:0]  held_vowel_next;
  logic [4:0]  held_final_next;
  logic [4:0]  previous_final_next;
  logic        emitted_in_word_next;

  // handshake between stages
  logic        s1_load;
  logic        s2_load;
  logic        s2_done;
  logic        room;

  // rule stage
  logic        emit_held;
  logic        emit_last;
  logic [4:0]  link_ini;
  logic [4:0]  link_fin;
  logic [4:0]  pf_after;
  logic        ew_after;
  logic        hv_after;
  logic [4:0]  hi_after;
  logic [4:0]  hvo_after;
  logic [4:0]  hf_after;
  syl_out_t    res_held;
  syl_out_t    res_last;
  syl_out_t    push_data0;
  logic [1:0]  push_n;
  syl_out_t    out_data;

  // a stage moves on when its successor frees up in the same cycle
  assign s2_done  = s2_valid && room;
  assign s2_load  = s1_valid && (!s2_valid || s2_done);
  assign in_ready = !s1_valid || !s2_valid || s2_done;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= 1'b1;
      else if (s2_load) s1_valid <= 1'b0;
      if (s2_load) s2_valid <= 1'b1;
      else if (s2_done) s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_code_point <= code_point;
      s1_word_end   <= word_end;
    end
    if (s2_load) begin
      s2_syl  <= dec_syl;
      s2_wend <= s1_word_end;
      s2_ini  <= dec_ini;
      s2_vow  <= dec_vow;
      s2_fin  <= dec_fin;
    end
  end

  hsp_decompose u_decompose (
    .code_point  (s1_code_point),
    .is_syllable (dec_syl),
    .ini         (dec_ini),
    .vow         (dec_vow),
    .fin         (dec_fin)
  );

  // boundary rules between the held syllable and the incoming one
  always_comb begin
    emit_held = s2_syl && held_valid;
    link_ini  = s2_ini;
    link_fin  = (held_final < 5'd28) ? held_final : FINAL_NONE;
    // final consonant other than ng moves into a null onset
    if ((link_fin != FINAL_NONE) && (link_fin != FINAL_NG) && (s2_ini == INIT_NULL)) begin
      link_ini = LINK_MOVE[link_fin];
      link_fin = LINK_KEEP[link_fin];
    end
    // n before l becomes l
    if ((link_fin == FINAL_N) && (link_ini == INIT_R))
      link_fin = FINAL_L;

    res_held = hsp_emit(previous_final, held_initial, held_vowel, link_fin, 1'b1, link_ini,
                        !emitted_in_word, 1'b0);

    // state as seen after the held syllable went out
    pf_after  = emit_held ? link_fin : previous_final;
    ew_after  = emitted_in_word || emit_held;
    hv_after  = held_valid || s2_syl;
    hi_after  = s2_syl ? link_ini : held_initial;
    hvo_after = s2_syl ? s2_vow : held_vowel;
    hf_after  = s2_syl ? s2_fin : held_final;

    // word end flushes whatever is held
    emit_last = s2_wend && hv_after;
    res_last  = hsp_emit(pf_after, hi_after, hvo_after, hf_after, 1'b0, FINAL_NONE,
                         !ew_after, 1'b1);

    push_data0 = emit_held ? res_held : res_last;
    push_n     = s2_done ? (2'(emit_held) + 2'(emit_last)) : 2'd0;

    if (s2_wend) begin
      held_valid_next      = 1'b0;
      held_initial_next    = '0;
      held_vowel_next      = '0;
      held_final_next      = '0;
      previous_final_next  = '0;
      emitted_in_word_next = 1'b0;
    end else begin
      held_valid_next      = hv_after;
      held_initial_next    = hi_after;
      held_vowel_next      = hvo_after;
      held_final_next      = hf_after;
      previous_final_next  = pf_after;
      emitted_in_word_next = ew_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid      <= 1'b0;
      held_initial    <= '0;
      held_vowel      <= '0;
      held_final      <= '0;
      previous_final  <= '0;
      emitted_in_word <= 1'b0;
    end else if (s2_done) begin
      held_valid      <= held_valid_next;
      held_initial    <= held_initial_next;
      held_vowel      <= held_vowel_next;
      held_final      <= held_final_next;
      previous_final  <= previous_final_next;
      emitted_in_word <= emitted_in_word_next;
    end
  end

  // result queue parts the rule stage from the output handshake
  hsp_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_result_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push_data0 (push_data0),
    .push_data1 (res_last),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign onset_symbol = out_data.onset;
  assign vowel_symbol = out_data.vowel;
  assign coda_symbol  = out_data.coda;
  assign word_first   = out_data.first;
  assign word_last    = out_data.last;

endmodule

`default_nettype wire
